[design/sakv_pkg.sv]
// Shared constants, request codes and controller/datapath interface types.
package sakv_pkg;

  // Default number of table slots.
  localparam int ENTRIES_DEF = 16;

  // Width of an index and of a stored value.
  localparam int DATA_W = 32;

  // Value returned by a read request whose index is absent.
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  // Value returned by every set request.
  localparam logic signed [DATA_W-1:0] SET_VALUE = '0;

  // Request codes.
  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // capture a new request and restart the scan
    logic scan_step;  // issue the next slot read and compare the previous one
    logic commit;     // update the table and load the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_more; // slots remain to be read
    logic cmp_valid;  // a slot read is waiting to be compared
    logic cmp_hit;    // the waiting slot holds the requested index
    logic out_free;   // the output register can take a result this cycle
  } ctl_stat_t;

endpackage

[design/sparse_array_key_value_table.sv]
// Sparse array key/value table built from a controller and a scanning datapath.
// The table keeps up to ENTRIES index/value pairs in the order their indices were
// first written. Each request is searched against the used slots one slot per
// clock through a single read port on each slot memory. After it is accepted, a
// request holds in_stall high through its scan and commit; the next request is
// taken once in_stall falls, so only one request is in progress at a time. Its
// result appears on out_valid as in_stall falls. A finished result sits in an
// output register, so the next request is taken while that result waits to be
// collected. A result that is still stalled when the next request finishes its
// scan holds that request in its last cycle. A set of a new index into a full
// table is dropped and reported with table_full.
module sparse_array_key_value_table #(
  parameter int ENTRIES = sakv_pkg::ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic signed [sakv_pkg::DATA_W-1:0]   in_index,
  input  logic signed [sakv_pkg::DATA_W-1:0]   in_write_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sakv_pkg::DATA_W-1:0]   out_read_value,
  output logic                                 out_found,
  output logic                                 out_table_full
);
  import sakv_pkg::*;

  ctl_cmd_t  ctl_cmd;
  ctl_stat_t ctl_stat;

  // Request sequencing.
  sakv_controller u_controller (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat_i   (ctl_stat),
    .cmd_o    (ctl_cmd)
  );

  // Storage, scan and result.
  sakv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_index       (in_index),
    .in_write_value (in_write_value),
    .cmd_i          (ctl_cmd),
    .stat_o         (ctl_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_found      (out_found),
    .out_table_full (out_table_full)
  );

endmodule

[design/sakv_controller.sv]
// Controller state machine that sequences the capture, scan and commit of a request.
module sakv_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sakv_pkg::ctl_stat_t  stat_i,
  output sakv_pkg::ctl_cmd_t   cmd_o
);
  import sakv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new request is taken only while no request is in progress.
  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load_req = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        // Stop on a match, or once every used slot has been compared.
        if (stat_i.cmp_valid && stat_i.cmp_hit) begin
          state_nxt = S_FINISH;
        end else if (!stat_i.cmp_valid && !stat_i.issue_more) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/sakv_datapath.sv]
// Datapath: request registers, slot memories, scan pointer, fill count and output register.
module sakv_datapath #(
  parameter int ENTRIES = sakv_pkg::ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_command,
  input  logic signed [sakv_pkg::DATA_W-1:0]   in_index,
  input  logic signed [sakv_pkg::DATA_W-1:0]   in_write_value,
  input  sakv_pkg::ctl_cmd_t                   cmd_i,
  output sakv_pkg::ctl_stat_t                  stat_o,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sakv_pkg::DATA_W-1:0]   out_read_value,
  output logic                                 out_found,
  output logic                                 out_table_full
);
  import sakv_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  // Slot memories.
  logic [DATA_W-1:0] key_mem [ENTRIES];
  logic [DATA_W-1:0] data_mem [ENTRIES];

  // Captured request.
  logic              req_cmd_r;
  logic [DATA_W-1:0] req_key_r;
  logic [DATA_W-1:0] req_val_r;

  // Scan control.
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [CNT_W-1:0]  used_count_r, used_count_nxt;

  // Registered memory read data.
  logic [DATA_W-1:0] key_q_r;
  logic [DATA_W-1:0] data_q_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r;
  logic              out_found_r;
  logic              out_full_r;

  logic              issue_more;
  logic              cmp_hit;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              has_room;
  logic              append;
  logic              data_we;
  logic [IDX_W-1:0]  wr_addr;
  logic              out_free;

  // Status towards the controller.
  assign issue_more = (rd_idx_r < used_count_r);
  assign cmp_hit    = (key_q_r == req_key_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign stat_o     = '{issue_more: issue_more, cmp_valid: rd_pend_r,
                        cmp_hit: cmp_hit, out_free: out_free};

  // A slot read is issued each scan cycle while used slots remain, until a match holds the read data.
  assign rd_en   = cmd_i.scan_step && issue_more && !(rd_pend_r && cmp_hit);
  assign rd_addr = rd_idx_r[IDX_W-1:0];

  // Table update at commit: overwrite a matching slot or append a new one.
  assign has_room = (used_count_r < FULL_COUNT);
  assign append   = cmd_i.commit && (req_cmd_r == CMD_SET) && !hit_r && has_room;
  assign data_we  = (cmd_i.commit && (req_cmd_r == CMD_SET) && hit_r) || append;
  assign wr_addr  = hit_r ? hit_idx_r : used_count_r[IDX_W-1:0];

  // Scan, fill count and output handshake next state.
  always_comb begin
    rd_idx_nxt     = rd_idx_r;
    rd_pend_nxt    = rd_pend_r;
    hit_nxt        = hit_r;
    used_count_nxt = used_count_r;
    out_valid_nxt  = out_valid_r;
    if (cmd_i.load_req) begin
      rd_idx_nxt  = '0;
      rd_pend_nxt = 1'b0;
      hit_nxt     = 1'b0;
    end else if (cmd_i.scan_step) begin
      if (rd_pend_r && cmp_hit) begin
        hit_nxt = 1'b1;
      end
      rd_pend_nxt = rd_en;
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
      end
    end
    if (append) begin
      used_count_nxt = used_count_r + CNT_W'(1);
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd_i.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      rd_pend_r    <= 1'b0;
      hit_r        <= 1'b0;
      used_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_idx_r     <= rd_idx_nxt;
      rd_pend_r    <= rd_pend_nxt;
      hit_r        <= hit_nxt;
      used_count_r <= used_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Request capture and match position.
  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      req_cmd_r <= in_command;
      req_key_r <= in_index;
      req_val_r <= in_write_value;
    end
    if (rd_en) begin
      cmp_idx_r <= rd_addr;
    end
    if (cmd_i.scan_step && rd_pend_r && cmp_hit) begin
      hit_idx_r <= cmp_idx_r;
    end
  end

  // Index memory.
  always_ff @(posedge clk) begin
    if (append) begin
      key_mem[wr_addr] <= req_key_r;
    end
    if (rd_en) begin
      key_q_r <= key_mem[rd_addr];
    end
  end

  // Value memory.
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[wr_addr] <= req_val_r;
    end
    if (rd_en) begin
      data_q_r <= data_mem[rd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      if (req_cmd_r == CMD_READ) begin
        out_value_r <= hit_r ? data_q_r : MISS_VALUE;
        out_full_r  <= 1'b0;
      end else begin
        out_value_r <= SET_VALUE;
        out_full_r  <= !hit_r && !has_room;
      end
      out_found_r <= hit_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_found      = out_found_r;
  assign out_table_full = out_full_r;

endmodule

[design/sakv_checker.sv]
// Port-level checks on the key/value table and the bind that attaches them.
module sakv_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [sakv_pkg::DATA_W-1:0] out_read_value,
  input logic                               out_found,
  input logic                               out_table_full
);
  import sakv_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A dropped set never reports a match and returns zero.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_found && (out_read_value == SET_VALUE))
    else $error("inconsistent table-full result");

  // Only one request is in progress: an accepted request blocks the next cycle.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted during a scan");

endmodule

bind sparse_array_key_value_table sakv_checker u_sakv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_found      (out_found),
  .out_table_full (out_table_full)
);
